// ===== design/u8tr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8tr_pkg
// shared types, constants and helpers for the utf-8 transcoder
// ----------------------------------------------------------------------------
package u8tr_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH        = 4;
  localparam int QUEUE_AW           = $clog2(QUEUE_DEPTH);

  localparam logic [20:0] CP_MAX        = 21'h10FFFF;
  localparam logic [20:0] SURR_LO       = 21'h00D800;
  localparam logic [20:0] SURR_HI       = 21'h00DFFF;
  localparam logic [20:0] SUPP_BASE     = 21'h010000;
  localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE = 16'hDC00;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_END_OK  = 2'd1,
    KIND_END_BAD = 2'd2
  } kind_t;

  // one queue entry: the results caused by one input transaction
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      n_bytes;
    logic            has_status;
    kind_t           status_kind;
    logic [15:0]     units;
    logic [15:0]     points;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // reported counts stop at 16 bits
  function automatic logic [15:0] clip16(input logic [31:0] v);
    logic [15:0] r;
    r = (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
    return r;
  endfunction

endpackage

// ===== design/u8tr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8tr_front
// decodes one utf-8 byte per transaction and builds the result job
// ----------------------------------------------------------------------------
module u8tr_front
  import u8tr_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  input  logic       empty_text,
  input  logic       form_sel,
  input  logic       q_full,
  output logic       push,
  output job_t       job
);

  localparam int CW1 = COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [20:0]           partial_value;
  logic [1:0]            bytes_pending;
  logic [2:0]            sequence_width;
  logic                  error_seen;
  logic [COUNT_BITS-1:0] unit_count;
  logic [COUNT_BITS-1:0] point_count;

  logic [20:0]           partial_value_next;
  logic [1:0]            bytes_pending_next;
  logic [2:0]            sequence_width_next;
  logic                  error_seen_next;
  logic [COUNT_BITS-1:0] unit_count_next;
  logic [COUNT_BITS-1:0] point_count_next;

  logic                  finish;
  logic                  ends;
  logic [20:0]           min_cp;
  logic [19:0]           offs;
  logic [15:0]           hi_unit;
  logic [15:0]           lo_unit;
  logic [CW1-1:0]        unit_sum;
  logic                  accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign ends     = empty_text || end_of_text;

  always_comb begin
    partial_value_next  = partial_value;
    bytes_pending_next  = bytes_pending;
    sequence_width_next = sequence_width;
    error_seen_next     = error_seen;
    unit_count_next     = unit_count;
    point_count_next    = point_count;
    finish              = 1'b0;
    min_cp              = 21'd0;
    offs                = 20'd0;
    hi_unit             = 16'd0;
    lo_unit             = 16'd0;
    unit_sum            = '0;
    job                 = '0;
    job.status_kind     = KIND_END_OK;

    // byte decode
    if (!empty_text && !error_seen) begin
      if (bytes_pending == 2'd0) begin
        if (in_byte[7] == 1'b0) begin
          partial_value_next  = {14'd0, in_byte[6:0]};
          sequence_width_next = 3'd1;
          finish              = 1'b1;
        end else if (in_byte[7:5] == 3'b110) begin
          partial_value_next  = {16'd0, in_byte[4:0]};
          sequence_width_next = 3'd2;
          bytes_pending_next  = 2'd1;
        end else if (in_byte[7:4] == 4'b1110) begin
          partial_value_next  = {17'd0, in_byte[3:0]};
          sequence_width_next = 3'd3;
          bytes_pending_next  = 2'd2;
        end else if (in_byte[7:3] == 5'b11110) begin
          partial_value_next  = {18'd0, in_byte[2:0]};
          sequence_width_next = 3'd4;
          bytes_pending_next  = 2'd3;
        end else begin
          error_seen_next = 1'b1;
        end
      end else begin
        if (in_byte[7:6] != 2'b10) begin
          error_seen_next = 1'b1;
        end else begin
          partial_value_next = {partial_value[14:0], in_byte[5:0]};
          bytes_pending_next = bytes_pending - 2'd1;
          finish             = (bytes_pending == 2'd1);
        end
      end
    end

    // code point complete: range checks and encoding
    if (finish) begin
      case (sequence_width_next)
        3'd2:    min_cp = 21'h000080;
        3'd3:    min_cp = 21'h000800;
        3'd4:    min_cp = SUPP_BASE;
        default: min_cp = 21'd0;
      endcase
      if (partial_value_next < min_cp || partial_value_next > CP_MAX ||
          (partial_value_next >= SURR_LO && partial_value_next <= SURR_HI)) begin
        error_seen_next = 1'b1;
      end else begin
        offs    = 20'(partial_value_next - SUPP_BASE);
        hi_unit = HIGH_SURR_BASE + {6'd0, offs[19:10]};
        lo_unit = LOW_SURR_BASE + {6'd0, offs[9:0]};
        if (form_sel) begin
          job.data    = {8'd0, 3'd0, partial_value_next[20:16],
                         partial_value_next[15:8], partial_value_next[7:0]};
          job.n_bytes = 3'd4;
        end else if (partial_value_next < SUPP_BASE) begin
          job.data    = {16'd0, partial_value_next[15:8], partial_value_next[7:0]};
          job.n_bytes = 3'd2;
        end else begin
          job.data    = {lo_unit[15:8], lo_unit[7:0], hi_unit[15:8], hi_unit[7:0]};
          job.n_bytes = 3'd4;
        end
        // saturating counts
        unit_sum = {1'b0, unit_count} +
                   ((partial_value_next >= SUPP_BASE) ? CW1'(2) : CW1'(1));
        unit_count_next = unit_sum[COUNT_BITS] ? CNT_MAX : unit_sum[COUNT_BITS-1:0];
        if (point_count != CNT_MAX) begin
          point_count_next = point_count + COUNT_BITS'(1);
        end
      end
    end

    // end of text: status and per-text clear
    if (ends) begin
      job.has_status = 1'b1;
      if (bytes_pending_next != 2'd0 || error_seen_next) begin
        job.status_kind = KIND_END_BAD;
      end else begin
        job.status_kind = KIND_END_OK;
        job.units       = clip16(32'(unit_count_next));
        job.points      = clip16(32'(point_count_next));
      end
      partial_value_next  = 21'd0;
      bytes_pending_next  = 2'd0;
      sequence_width_next = 3'd0;
      error_seen_next     = 1'b0;
      unit_count_next     = '0;
      point_count_next    = '0;
    end
  end

  assign push = accept && (job.has_status || job.n_bytes != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value  <= 21'd0;
      bytes_pending  <= 2'd0;
      sequence_width <= 3'd0;
      error_seen     <= 1'b0;
      unit_count     <= '0;
      point_count    <= '0;
    end else if (accept) begin
      partial_value  <= partial_value_next;
      bytes_pending  <= bytes_pending_next;
      sequence_width <= sequence_width_next;
      error_seen     <= error_seen_next;
      unit_count     <= unit_count_next;
      point_count    <= point_count_next;
    end
  end

endmodule

// ===== design/u8tr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8tr_queue
// small job fifo between decoder and serialiser
// ----------------------------------------------------------------------------
module u8tr_queue
  import u8tr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  job_t          push_job,
  input  logic          pop,
  output job_t          head_job,
  output queue_status_t status
);

  job_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;

  assign status.full  = (fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign head_job     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

// ===== design/u8tr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8tr_back
// walks the head job one result per cycle into the output register while the consumer is ready
// ----------------------------------------------------------------------------
module u8tr_back
  import u8tr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  job_t          head_job,
  input  queue_status_t q_status,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic [1:0]    kind,
  output logic [15:0]   utf16_units,
  output logic [15:0]   code_points,
  output logic          last_of_run
);

  logic [2:0] idx;
  logic [2:0] total;
  logic       load;
  logic       take;
  logic       is_last;
  logic       is_data;

  assign load    = !out_valid || out_ready;
  assign take    = load && !q_status.empty;
  assign total   = head_job.n_bytes + {2'd0, head_job.has_status};
  assign is_last = (idx == total - 3'd1);
  assign is_data = (idx < head_job.n_bytes);
  assign pop     = take && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (load) begin
      out_valid <= !q_status.empty;
      if (take) begin
        idx <= is_last ? 3'd0 : idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      last_of_run <= is_last;
      if (is_data) begin
        out_byte    <= head_job.data[idx[1:0]];
        kind        <= KIND_DATA;
        utf16_units <= 16'd0;
        code_points <= 16'd0;
      end else begin
        out_byte    <= 8'd0;
        kind        <= head_job.status_kind;
        utf16_units <= head_job.units;
        code_points <= head_job.points;
      end
    end
  end

endmodule

// ===== design/utf8_to_utf16_utf32_transcoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_utf32_transcoder
// utf-8 byte stream to utf-16le / utf-32le bytes with end-of-text status
// ----------------------------------------------------------------------------
//
// channel  direction  handshake              payload
// in       sink       in_valid / in_ready    in_byte, end_of_text, empty_text
// out      source     out_valid / out_ready  out_byte, kind, utf16_units,
//                                            code_points, last_of_run
// cfg      sink       cfg_valid / cfg_ready  output_form
//
// the decoder takes one input transaction per cycle while the job queue has
// room; each transaction leaves zero to five results in one queue entry
// the output side sends one result per cycle while out_ready is high, so the
// sustained rate is set by the output port, where ascii in utf-32 form gives
// four results per input byte; up to four jobs buffer a stalled consumer
// synchronous active-high reset clears decoder state, form register, queue and output valid
// ----------------------------------------------------------------------------
module utf8_to_utf16_utf32_transcoder
  import u8tr_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // input bytes
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_text,
  input  logic        empty_text,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  kind,
  output logic [15:0] utf16_units,
  output logic [15:0] code_points,
  output logic        last_of_run,
  // register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        output_form
);

  // output form register: 0 utf-16le, 1 utf-32le
  logic          form_sel;

  // queue hookup
  logic          q_push;
  logic          q_pop;
  job_t          q_in_job;
  job_t          q_head_job;
  queue_status_t q_status;

  // register port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      form_sel <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      form_sel <= output_form;
    end
  end

  // decoder: validates bytes, keeps counts, builds one job per transaction
  u8tr_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .empty_text  (empty_text),
    .form_sel    (form_sel),
    .q_full      (q_status.full),
    .push        (q_push),
    .job         (q_in_job)
  );

  // decouples decoder from a stalled consumer
  u8tr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_in_job),
    .pop      (q_pop),
    .head_job (q_head_job),
    .status   (q_status)
  );

  // serialiser: one result transaction per cycle from the head job while the consumer is ready
  u8tr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_job    (q_head_job),
    .q_status    (q_status),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .kind        (kind),
    .utf16_units (utf16_units),
    .code_points (code_points),
    .last_of_run (last_of_run)
  );

  // no job is written into a full queue
  assert property (@(posedge clk) disable iff (rst) !(q_push && q_status.full))
    else $error("job pushed into full queue");

  // no job is retired from an empty queue
  assert property (@(posedge clk) disable iff (rst) !(q_pop && q_status.empty))
    else $error("job popped from empty queue");

  // a status result always closes its run
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_DATA) |-> last_of_run)
    else $error("status result not marked last of run");

  // a stalled result stays put until the consumer takes it
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(kind) &&
      $stable(utf16_units) && $stable(code_points) && $stable(last_of_run)))
    else $error("stalled result changed before it was taken");

endmodule
